[src/tkf_pkg.sv]
// Shared constants and types for the top-k frequent value tracker.
`timescale 1ns / 1ps
package tkf_pkg;

  localparam int VALUE_BITS  = 10;
  localparam int MAX_K       = 16;
  localparam int COUNT_BITS  = 16;
  localparam int TABLE_DEPTH = 1 << VALUE_BITS;
  localparam int IDX_BITS    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int K_BITS      = 5;
  localparam int RANK_BITS   = 4;
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;

  localparam logic [K_BITS-1:0]     K_RESET   = K_BITS'(4);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [ADDR_BITS-3:0] REG_K = '0;

  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] count;
    logic                  above;
    logic                  seen;
  } tkf_link_t;

endpackage

[src/top_k_frequent_stream.sv]
// Top level: frequency table, chain of rank cells, control sequencer and APB register.
// After reset all 1024 count memory entries are cleared while in_stall stays high.
// An accepted value is counted and the list updated in the next cycle; result beats then
// follow from S_EMIT, one per cycle while out_stall does not hold the output register.
// An item with no rank to report leaves S_EMIT at once.
// Reset sets k to 4 and empties the list.
`timescale 1ns / 1ps
module top_k_frequent_stream (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [tkf_pkg::VALUE_BITS-1:0]         in_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [tkf_pkg::VALUE_BITS-1:0]         out_value_res,
  output logic [tkf_pkg::RANK_BITS-1:0]          out_rank,
  output logic                                   out_last,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tkf_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [tkf_pkg::DATA_BITS-1:0]          pwdata,
  output logic [tkf_pkg::DATA_BITS-1:0]          prdata,
  output logic                                   pready
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_EMIT
  } state_t;

  state_t                         state_r;
  logic [tkf_pkg::VALUE_BITS-1:0] clr_addr_r;
  logic [tkf_pkg::VALUE_BITS-1:0] v_r;
  logic [tkf_pkg::IDX_BITS-1:0]   idx_r;
  logic [tkf_pkg::K_BITS-1:0]     k_r;
  logic                           out_valid_r;
  logic [tkf_pkg::VALUE_BITS-1:0] out_value_r;
  logic [tkf_pkg::RANK_BITS-1:0]  out_rank_r;
  logic                           out_last_r;

  logic                           in_accept;
  logic                           mem_we;
  logic [tkf_pkg::VALUE_BITS-1:0] mem_waddr;
  logic [tkf_pkg::COUNT_BITS-1:0] mem_wdata;
  logic [tkf_pkg::COUNT_BITS-1:0] rd_count;
  logic                           sat;
  logic [tkf_pkg::COUNT_BITS-1:0] cnt_new;
  logic                           cell_upd;
  logic                           reg_sel;
  logic                           cfg_write;

  tkf_pkg::tkf_link_t             links [tkf_pkg::MAX_K + 1];
  logic [tkf_pkg::MAX_K-1:0]      valid_vec;
  logic [tkf_pkg::MAX_K-1:0]      valid_shift;
  logic [tkf_pkg::VALUE_BITS-1:0] val_arr [tkf_pkg::MAX_K];

  logic                           emit_ok;
  logic                           is_last;
  logic                           slot_free;
  logic                           load_beat;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign sat      = (rd_count == tkf_pkg::COUNT_MAX);
  assign cnt_new  = rd_count + tkf_pkg::COUNT_BITS'(1);
  assign cell_upd = (state_r == S_UPD) && !sat;

  assign mem_we    = (state_r == S_CLEAR) || cell_upd;
  assign mem_waddr = (state_r == S_CLEAR) ? clr_addr_r : v_r;
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : cnt_new;

  tkf_freq_table u_table (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (in_accept),
    .raddr   (in_value),
    .rdata_r (rd_count)
  );

  assign links[0] = '0;

  for (genvar gi = 0; gi < tkf_pkg::MAX_K; gi++) begin : g_cell
    tkf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .upd       (cell_upd),
      .new_value (v_r),
      .new_count (cnt_new),
      .prev      (links[gi]),
      .link_o    (links[gi+1])
    );
    assign valid_vec[gi] = links[gi+1].valid;
    assign val_arr[gi]   = links[gi+1].value;
  end

  assign valid_shift = valid_vec >> 1;
  assign emit_ok     = valid_vec[idx_r] && (32'(idx_r) < 32'(k_r));
  assign is_last     = (idx_r == tkf_pkg::IDX_BITS'(tkf_pkg::MAX_K - 1)) ||
                       !valid_shift[idx_r] || ((32'(idx_r) + 32'd1) >= 32'(k_r));
  assign slot_free   = !out_valid_r || !out_stall;
  assign load_beat   = (state_r == S_EMIT) && emit_ok && slot_free;

  assign reg_sel   = (paddr[tkf_pkg::ADDR_BITS-1:2] == tkf_pkg::REG_K);
  assign cfg_write = psel && penable && pwrite && reg_sel;
  assign pready    = 1'b1;
  assign prdata    = reg_sel ? tkf_pkg::DATA_BITS'(k_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= tkf_pkg::K_RESET;
    end else if (cfg_write) begin
      k_r <= pwdata[tkf_pkg::K_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      v_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= load_beat || (out_valid_r && out_stall);
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          idx_r   <= '0;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!emit_ok) begin
            state_r <= S_IDLE;
          end else if (slot_free) begin
            out_value_r <= val_arr[idx_r];
            out_rank_r  <= tkf_pkg::RANK_BITS'(idx_r);
            out_last_r  <= is_last;
            idx_r       <= idx_r + 1'b1;
            if (is_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_rank      = out_rank_r;
  assign out_last      = out_last_r;

endmodule

[src/tkf_freq_table.sv]
// Frequency count memory with one write port and one registered read port.
`timescale 1ns / 1ps
module tkf_freq_table (
  input  logic                           clk,
  input  logic                           we,
  input  logic [tkf_pkg::VALUE_BITS-1:0] waddr,
  input  logic [tkf_pkg::COUNT_BITS-1:0] wdata,
  input  logic                           re,
  input  logic [tkf_pkg::VALUE_BITS-1:0] raddr,
  output logic [tkf_pkg::COUNT_BITS-1:0] rdata_r
);

  logic [tkf_pkg::COUNT_BITS-1:0] mem [tkf_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

[src/tkf_cell.sv]
// One rank of the sorted top list: compares against the updated entry and shifts.
`timescale 1ns / 1ps
module tkf_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           upd,
  input  logic [tkf_pkg::VALUE_BITS-1:0] new_value,
  input  logic [tkf_pkg::COUNT_BITS-1:0] new_count,
  input  tkf_pkg::tkf_link_t             prev,
  output tkf_pkg::tkf_link_t             link_o
);

  logic                           valid_r, valid_nxt;
  logic [tkf_pkg::VALUE_BITS-1:0] value_r, value_nxt;
  logic [tkf_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic                           own_above;
  logic                           match;
  logic                           take_new;
  logic                           take_prev;

  always_comb begin
    own_above = !valid_r || (new_count > count_r) ||
                ((new_count == count_r) && (new_value < value_r));
    match     = valid_r && (value_r == new_value);
    take_new  = upd && own_above && !prev.above;
    take_prev = upd && prev.above && !prev.seen;
    valid_nxt = valid_r;
    value_nxt = value_r;
    count_nxt = count_r;
    if (take_new) begin
      valid_nxt = 1'b1;
      value_nxt = new_value;
      count_nxt = new_count;
    end else if (take_prev) begin
      valid_nxt = prev.valid;
      value_nxt = prev.value;
      count_nxt = prev.count;
    end
    link_o.valid = valid_r;
    link_o.value = value_r;
    link_o.count = count_r;
    link_o.above = own_above;
    link_o.seen  = prev.seen | match;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    count_r <= count_nxt;
  end

endmodule

[src/tkf_checker.sv]
// Port-level checks for the top-k frequent value tracker, bound to the top level.
`timescale 1ns / 1ps
module tkf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [tkf_pkg::VALUE_BITS-1:0] out_value_res,
  input logic [tkf_pkg::RANK_BITS-1:0]  out_rank,
  input logic                           out_last
);

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Input accepted in two consecutive cycles.");

  a_no_accept_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> in_stall)
    else $error("Input accepted while results of an item are still pending.");

  a_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_value_res) && $stable(out_rank) && $stable(out_last)))
    else $error("Stalled result beat changed.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_stall))
    else $error("Block not quiet after reset.");

endmodule

bind top_k_frequent_stream tkf_checker u_tkf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value_res (out_value_res),
  .out_rank      (out_rank),
  .out_last      (out_last)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for the top-k frequent value tracker.
`timescale 1ns / 1ps
module tb_top;

  localparam int VALUE_BITS  = tkf_pkg::VALUE_BITS;
  localparam int MAX_K       = tkf_pkg::MAX_K;
  localparam int COUNT_BITS  = tkf_pkg::COUNT_BITS;
  localparam int TABLE_DEPTH = tkf_pkg::TABLE_DEPTH;
  localparam int K_BITS      = tkf_pkg::K_BITS;
  localparam int RANK_BITS   = tkf_pkg::RANK_BITS;
  localparam int ADDR_BITS   = tkf_pkg::ADDR_BITS;
  localparam int DATA_BITS   = tkf_pkg::DATA_BITS;
  localparam logic [K_BITS-1:0]     K_RESET   = tkf_pkg::K_RESET;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = tkf_pkg::COUNT_MAX;
  localparam logic [ADDR_BITS-3:0]  REG_K     = tkf_pkg::REG_K;

  localparam int POOL_N = 24;
  localparam int LATENCY = MAX_K + 4;
  localparam int IDLE_LIMIT = 8000;
  localparam int RANDOM_PER_PHASE = 75;
  localparam logic [ADDR_BITS-3:0] REG_SPARE = 1'b1;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} exp_mode_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [ADDR_BITS-3:0]  idx;
    logic [DATA_BITS-1:0]  data;
    exp_mode_t             mode;
    logic [VALUE_BITS-1:0] exp_value;
  } row_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RANK_BITS-1:0]  rank;
    logic                  last;
  } rank_beat_t;

  localparam row_t DIRECTED [36] = '{
    '{ROW_ITEM,  REG_K,     32'd1023, EXP_ONE,   10'd1023},
    '{ROW_ITEM,  REG_K,     32'd0,    EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd1023, EXP_MODEL, 10'd0},
    '{ROW_WRITE, REG_SPARE, 32'd1,    EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd5,    EXP_MODEL, 10'd0},
    '{ROW_WRITE, REG_K,     32'd1,    EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd0,    EXP_ONE,   10'd0},
    '{ROW_WRITE, REG_K,     32'd0,    EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd7,    EXP_NONE,  10'd0},
    '{ROW_ITEM,  REG_K,     32'd7,    EXP_NONE,  10'd0},
    '{ROW_WRITE, REG_K,     32'd31,   EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd200,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd201,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd202,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd203,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd204,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd205,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd206,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd207,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd208,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd209,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd210,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd211,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd900,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd3,    EXP_MODEL, 10'd0},
    '{ROW_WRITE, REG_K,     32'd16,   EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd211,  EXP_MODEL, 10'd0},
    '{ROW_WRITE, REG_K,     32'd17,   EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd511,  EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd512,  EXP_MODEL, 10'd0},
    '{ROW_WRITE, REG_K,     32'd2,    EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd1023, EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd0,    EXP_MODEL, 10'd0},
    '{ROW_WRITE, REG_K,     32'd4,    EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd5,    EXP_MODEL, 10'd0},
    '{ROW_ITEM,  REG_K,     32'd6,    EXP_MODEL, 10'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VALUE_BITS-1:0] out_value_res;
  logic [RANK_BITS-1:0]  out_rank;
  logic                  out_last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_BITS-1:0]  paddr = '0;
  logic [DATA_BITS-1:0]  pwdata = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  logic [COUNT_BITS-1:0] value_count [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] list_value [MAX_K];
  logic [COUNT_BITS-1:0] list_count [MAX_K];
  int                    list_fill = 0;
  logic [K_BITS-1:0]     k_shadow = K_RESET;
  rank_beat_t            expected_ranks [$];

  int snd_pct = 0;
  int rcv_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int idle_cycles = 0;

  top_k_frequent_stream i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value_res(out_value_res),
    .out_rank     (out_rank),
    .out_last     (out_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit outranks(input logic [COUNT_BITS-1:0] ca,
                                  input logic [VALUE_BITS-1:0] va,
                                  input logic [COUNT_BITS-1:0] cb,
                                  input logic [VALUE_BITS-1:0] vb);
    if (ca != cb) return ca > cb;
    return va < vb;
  endfunction

  task automatic promote_entry(input int start);
    int                    p;
    logic [VALUE_BITS-1:0] tv;
    logic [COUNT_BITS-1:0] tc;
    p = start;
    while (p > 0 &&
           outranks(list_count[p], list_value[p], list_count[p-1], list_value[p-1])) begin
      tv = list_value[p];
      tc = list_count[p];
      list_value[p] = list_value[p-1];
      list_count[p] = list_count[p-1];
      list_value[p-1] = tv;
      list_count[p-1] = tc;
      p--;
    end
  endtask

  task automatic count_and_rank(input logic [VALUE_BITS-1:0] v, input bit push);
    logic [COUNT_BITS-1:0] c;
    int                    pos;
    int                    lim;
    int                    n;
    rank_beat_t            beat;
    pos = -1;
    if (value_count[v] != COUNT_MAX) begin
      c = value_count[v] + 1'b1;
      value_count[v] = c;
      for (int i = 0; i < list_fill; i++) begin
        if (pos < 0 && list_value[i] == v) pos = i;
      end
      if (pos >= 0) begin
        list_count[pos] = c;
        promote_entry(pos);
      end else if (list_fill < MAX_K) begin
        list_value[list_fill] = v;
        list_count[list_fill] = c;
        list_fill++;
        promote_entry(list_fill - 1);
      end else if (outranks(c, v, list_count[MAX_K-1], list_value[MAX_K-1])) begin
        list_value[MAX_K-1] = v;
        list_count[MAX_K-1] = c;
        promote_entry(MAX_K - 1);
      end
    end
    lim = (k_shadow > MAX_K) ? MAX_K : int'(k_shadow);
    n = (list_fill < lim) ? list_fill : lim;
    if (push) begin
      for (int i = 0; i < n; i++) begin
        beat.value = list_value[i];
        beat.rank  = RANK_BITS'(i);
        beat.last  = (i == n - 1);
        expected_ranks.insert(expected_ranks.size(), beat);
      end
    end
  endtask

  task automatic send_value(input logic [VALUE_BITS-1:0] v, input exp_mode_t mode,
                            input logic [VALUE_BITS-1:0] typed_value);
    rank_beat_t beat;
    while ($urandom_range(0, 99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    count_and_rank(v, mode == EXP_MODEL);
    if (mode == EXP_ONE) begin
      beat.value = typed_value;
      beat.rank  = '0;
      beat.last  = 1'b1;
      expected_ranks.insert(expected_ranks.size(), beat);
    end
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ADDR_BITS-3:0] idx, input logic [DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_K) k_shadow = data[K_BITS-1:0];
  endtask

  // Every accepted result beat is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ranks.size() == 0) begin
        $display("%0t: unexpected beat value_res %0d rank %0d last %0d",
                 $time, out_value_res, out_rank, out_last);
        errors++;
      end else begin
        if (out_value_res !== expected_ranks[0].value) begin
          $display("%0t: value_res expected %0d got %0d", $time,
                   expected_ranks[0].value, out_value_res);
          errors++;
        end
        if (out_rank !== expected_ranks[0].rank) begin
          $display("%0t: rank expected %0d got %0d", $time, expected_ranks[0].rank, out_rank);
          errors++;
        end
        if (out_last !== expected_ranks[0].last) begin
          $display("%0t: last expected %0d got %0d", $time, expected_ranks[0].last, out_last);
          errors++;
        end
        void'(expected_ranks.pop_front());
        beats_checked++;
      end
    end
    out_stall <= ($urandom_range(0, 99) < rcv_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [VALUE_BITS-1:0] pool [POOL_N];
    logic [VALUE_BITS-1:0] v;
    int                    phase_k;
    for (int i = 0; i < TABLE_DEPTH; i++) value_count[i] = '0;
    for (int i = 0; i < MAX_K; i++) begin
      list_value[i] = '0;
      list_count[i] = '0;
    end
    for (int i = 0; i < POOL_N; i++) pool[i] = VALUE_BITS'($urandom_range(0, TABLE_DEPTH - 1));
    pool[0] = '0;
    pool[1] = '1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < $size(DIRECTED); r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        settle();
        cfg_write(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        send_value(DIRECTED[r].data[VALUE_BITS-1:0], DIRECTED[r].mode, DIRECTED[r].exp_value);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: phase_k = 16;
        1: phase_k = $urandom_range(2, 15);
        2: phase_k = $urandom_range(17, 31);
        default: phase_k = 1;
      endcase
      settle();
      cfg_write(REG_K, ($urandom() & ~32'h1F) | DATA_BITS'(phase_k));
      snd_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 46 : 33) : 0;
      rcv_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 46 : 33) : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(0, 3) != 0) v = pool[$urandom_range(0, $urandom_range(0, POOL_N - 1))];
        else v = VALUE_BITS'($urandom_range(0, TABLE_DEPTH - 1));
        send_value(v, EXP_MODEL, '0);
      end
    end

    settle();
    $display("Sent %0d values and checked %0d result beats across k from 0 to 31,",
             items_sent, beats_checked);
    $display("four flow-control mixes, an ignored spare register and list eviction.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
